// File: rtl/core/mabd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the arrangement bound decider.
// No dependencies; imported by max_arrangement_bound_decider.
package mabd_pkg;

   localparam int MAX_NODES  = 256;
   localparam int NODE_W     = 9;
   localparam int HIST_DEPTH = 256;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int COUNT_W    = 8;
   localparam int ACC_W      = 24;

   typedef logic [HIST_AW-1:0] hist_addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [1:0]         mode_type;
   typedef logic [1:0]         action_type;

   localparam mode_type MODE_START  = 2'd0;
   localparam mode_type MODE_BORDER = 2'd1;
   localparam mode_type MODE_EDGE   = 2'd2;
   localparam mode_type MODE_FINISH = 2'd3;

   localparam action_type ACT_PRUNE       = 2'd0;
   localparam action_type ACT_LEAF_INDSET = 2'd1;
   localparam action_type ACT_INDSET      = 2'd2;
   localparam action_type ACT_CONTINUE    = 2'd3;

   localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(MAX_NODES);

endpackage

// File: rtl/core/max_arrangement_bound_decider.sv
`timescale 1ns / 1ps
// Upper bound and action decision for one branch-and-bound step of a maximum
// linear arrangement search. Depends on mabd_pkg.

// A start request, which latches the costs and clears the count histogram, and a
// crossing-edge request leave busy low, while a border request holds busy high
// through the border state because it reads, increments and writes back one
// histogram entry in the histogram memory. A finish request walks all HIST_DEPTH
// histogram entries one memory read per cycle, followed by a short arithmetic
// pipeline, and busy stays high until the result strobe rsp_valid rises at the
// same clock edge at which busy falls. The result
// is held for exactly one cycle and the receiver cannot stall it. Configuration
// writes to node_count must be made while busy is low.
module max_arrangement_bound_decider
   import mabd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [31:0]       req_placed_cost,
   input  logic [31:0]       req_crossing_cost,
   input  logic [7:0]        req_position,
   input  logic [7:0]        req_suffix_edges,
   input  logic [31:0]       req_best_so_far,
   input  logic [7:0]        req_neighbor_count,
   input  logic              req_first_end_assigned,
   input  logic              req_second_end_assigned,
   input  logic [7:0]        req_first_end_degree,
   input  logic [7:0]        req_second_end_degree,
   output logic              rsp_valid,
   output logic [1:0]        rsp_action,
   output logic [31:0]       rsp_upper_bound,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BORDER = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   localparam hist_addr_type ADDR_TOP = HIST_AW'(HIST_DEPTH - 1);

   logic [2:0]          state_ff, state_in;
   logic [NODE_W-1:0]   node_count_ff;
   logic [31:0]         placed_ff, crossing_ff, best_ff;
   logic [7:0]          position_ff, suffix_ff;
   logic                leaves_ff;

   count_type           hist_mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] hist_vld_ff;
   count_type           rd_data_ff;
   logic                rd_vld_ff;
   hist_addr_type       rd_addr;
   hist_addr_type       addr_ff;
   hist_addr_type       wb_addr_ff;
   count_type           hist_count;
   logic                hist_we;

   logic                accept;
   logic                acc_finish;
   logic                pipe_empty;

   logic [NODE_W-1:0]   eff_nodes;
   logic [NODE_W-1:0]   pos_plus1;
   logic [NODE_W-1:0]   len_start;
   logic [NODE_W-1:0]   n_start;

   logic [7:0]          len_ff;
   logic [7:0]          take;
   logic                p0_vld_ff;
   hist_addr_type       p0_k_ff;
   logic                s1_vld_ff;
   logic [7:0]          s1_t_ff, s1_len_ff;
   hist_addr_type       s1_k_ff;
   logic [9:0]          s2_span;
   logic [17:0]         s2_prod;
   logic                s2_vld_ff;
   logic [14:0]         s2_w_ff;
   hist_addr_type       s2_k_ff;
   logic                s3_vld_ff;
   logic [22:0]         s3_p_ff;
   logic [ACC_W-1:0]    acc_ff;

   logic [NODE_W-1:0]   n_ff;
   logic [16:0]         nm_ff;
   logic [15:0]         mm_ff;
   logic [18:0]         sfx_plus, sfx_minus;
   logic [16:0]         sfx_ff;
   logic [32:0]         cp_ff;
   logic [33:0]         pre_ff;
   logic [34:0]         ub_ff;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign acc_finish = accept && (req_mode == MODE_FINISH);
   assign pipe_empty = !p0_vld_ff && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;

   assign eff_nodes = (node_count_ff > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                            : node_count_ff;
   assign pos_plus1 = {1'b0, position_ff} + NODE_W'(1);
   assign len_start = (eff_nodes > pos_plus1) ? (eff_nodes - pos_plus1) : '0;
   assign n_start   = (eff_nodes > {1'b0, position_ff})
                      ? (eff_nodes - {1'b0, position_ff}) : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_BORDER)) begin
               state_in = ST_BORDER;
            end else if (acc_finish) begin
               state_in = ST_WALK;
            end
         end
         ST_BORDER: state_in = ST_IDLE;
         ST_WALK: begin
            if (addr_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         placed_ff     <= '0;
         crossing_ff   <= '0;
         best_ff       <= '0;
         position_ff   <= '0;
         suffix_ff     <= '0;
         leaves_ff     <= 1'b1;
         hist_vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (accept && (req_mode == MODE_START)) begin
            placed_ff   <= req_placed_cost;
            crossing_ff <= req_crossing_cost;
            best_ff     <= req_best_so_far;
            position_ff <= req_position;
            suffix_ff   <= req_suffix_edges;
            leaves_ff   <= 1'b1;
            hist_vld_ff <= '0;
         end else if (accept && (req_mode == MODE_EDGE)) begin
            if (req_first_end_assigned) begin
               leaves_ff <= leaves_ff && (req_second_end_degree == 8'd1);
            end else if (req_second_end_assigned) begin
               leaves_ff <= leaves_ff && (req_first_end_degree == 8'd1);
            end
         end
         if (hist_we) begin
            hist_vld_ff[wb_addr_ff] <= 1'b1;
         end
      end
   end

   assign rd_addr    = (state_ff == ST_IDLE) ? req_neighbor_count : addr_ff;
   assign hist_count = rd_vld_ff ? rd_data_ff : '0;
   assign hist_we    = (state_ff == ST_BORDER) && (hist_count != '1);

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      rd_vld_ff  <= hist_vld_ff[rd_addr];
      if (hist_we) begin
         hist_mem[wb_addr_ff] <= hist_count + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wb_addr_ff <= req_neighbor_count;
      end
      if (acc_finish) begin
         addr_ff <= ADDR_TOP;
      end else if (state_ff == ST_WALK) begin
         addr_ff <= addr_ff - HIST_AW'(1);
      end
   end

   assign take    = (hist_count < len_ff) ? hist_count : len_ff;
   assign s2_span = {1'b0, s1_len_ff, 1'b0} - {2'b00, s1_t_ff} + 10'd1;
   assign s2_prod = s1_t_ff * s2_span;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         p0_vld_ff <= (state_ff == ST_WALK);
         s1_vld_ff <= p0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_k_ff <= addr_ff;
      if (acc_finish) begin
         len_ff <= len_start[7:0];
      end else if (p0_vld_ff) begin
         len_ff <= len_ff - take;
      end
      s1_t_ff   <= take;
      s1_len_ff <= len_ff;
      s1_k_ff   <= p0_k_ff;
      s2_w_ff   <= s2_prod[15:1];
      s2_k_ff   <= s1_k_ff;
      s3_p_ff   <= s2_w_ff * s2_k_ff;
      if (acc_finish) begin
         acc_ff <= '0;
      end else if (s3_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(s3_p_ff);
      end
   end

   assign sfx_plus  = {nm_ff, 2'b00} + 19'(suffix_ff[0]);
   assign sfx_minus = 19'(mm_ff) + {9'd0, suffix_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (acc_finish) begin
         n_ff  <= n_start;
         cp_ff <= {1'b0, crossing_ff} + {1'b0, placed_ff};
      end
      nm_ff  <= n_ff * suffix_ff;
      mm_ff  <= suffix_ff * suffix_ff;
      sfx_ff <= (sfx_plus >= sfx_minus) ? 17'((sfx_plus - sfx_minus) >> 2) : '0;
      pre_ff <= {1'b0, cp_ff} + 34'(sfx_ff);
      if (state_ff == ST_SUM) begin
         ub_ff <= {1'b0, pre_ff} + 35'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         if (ub_ff < {3'b000, best_ff}) begin
            rsp_action <= ACT_PRUNE;
         end else if (suffix_ff == '0) begin
            rsp_action <= leaves_ff ? ACT_LEAF_INDSET : ACT_INDSET;
         end else begin
            rsp_action <= ACT_CONTINUE;
         end
         rsp_upper_bound <= (ub_ff[34:32] != 3'b000) ? '1 : ub_ff[31:0];
      end
   end

`ifndef SYNTH
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result issued while the sequencer is still active");

   a_walk_begin : assert property (@(posedge clock) disable iff (reset)
      acc_finish |=> ((state_ff == ST_WALK) && (addr_ff == ADDR_TOP)))
      else $error("finish request did not start the histogram walk at the top");

   a_take_bound : assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (s1_t_ff <= s1_len_ff))
      else $error("vertex count taken exceeds the remaining length");

   a_pipe_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> pipe_empty)
      else $error("bound summed before the walk pipeline drained");
`endif

endmodule

// File: dv/mabd_bound_checker.sv
`timescale 1ns / 1ps
// Checker for the arrangement bound decider: watches the request, result and
// register ports, predicts each bound and action, and compares. Uses mabd_pkg.
module mabd_bound_checker
   import mabd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [31:0]       req_placed_cost,
   input  logic [31:0]       req_crossing_cost,
   input  logic [7:0]        req_position,
   input  logic [7:0]        req_suffix_edges,
   input  logic [31:0]       req_best_so_far,
   input  logic [7:0]        req_neighbor_count,
   input  logic              req_first_end_assigned,
   input  logic              req_second_end_assigned,
   input  logic [7:0]        req_first_end_degree,
   input  logic [7:0]        req_second_end_degree,
   input  logic              rsp_valid,
   input  logic [1:0]        rsp_action,
   input  logic [31:0]       rsp_upper_bound,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data,
   output int unsigned       failures,
   output int unsigned       pending,
   output int unsigned       bounds_checked
);

   typedef struct {
      action_type  action;
      logic [31:0] upper_bound;
   } bound_result_t;

   count_type         hist [HIST_DEPTH];
   logic [31:0]       placed_q;
   logic [31:0]       crossing_q;
   logic [31:0]       best_q;
   logic [7:0]        position_q;
   logic [7:0]        suffix_q;
   logic              leaves_q;
   logic [NODE_W-1:0] node_count_q;
   bound_result_t     expected_bounds [$];
   int unsigned       fail_count = 0;
   int unsigned       pending_count = 0;
   int unsigned       checked_count = 0;

   assign failures       = fail_count;
   assign pending        = pending_count;
   assign bounds_checked = checked_count;

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
   endtask

   function automatic bound_result_t predict_bound();
      longint unsigned nodes;
      longint unsigned pos;
      longint unsigned len;
      longint unsigned border;
      longint unsigned n;
      longint unsigned m;
      longint unsigned plus;
      longint unsigned minus;
      longint unsigned suffix;
      longint unsigned total;
      int              k;
      int              c;
      bound_result_t   r;
      nodes = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
      pos = position_q;
      len = (nodes > pos + 1) ? nodes - pos - 1 : 0;
      border = 0;
      for (k = HIST_DEPTH - 1; k >= 0; k--) begin
         for (c = 0; c < hist[k]; c++) begin
            border += len * longint'(k);
            if (len > 0) len--;
         end
      end
      n = (nodes > pos) ? nodes - pos : 0;
      m = suffix_q;
      plus = 4 * n * m + (m % 2);
      minus = m * m + 4 * m;
      suffix = (minus > plus) ? 0 : (plus - minus) / 4;
      total = longint'(crossing_q) + border + suffix + longint'(placed_q);
      if (total < longint'(best_q)) r.action = ACT_PRUNE;
      else if (m == 0) r.action = leaves_q ? ACT_LEAF_INDSET : ACT_INDSET;
      else r.action = ACT_CONTINUE;
      r.upper_bound = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      bound_result_t got;
      if (reset) begin
         foreach (hist[i]) hist[i] = '0;
         placed_q     = '0;
         crossing_q   = '0;
         best_q       = '0;
         position_q   = '0;
         suffix_q     = '0;
         leaves_q     = 1'b1;
         node_count_q = NODE_COUNT_RESET;
         expected_bounds.delete();
      end else begin
         if (csr_wr_en) node_count_q = csr_wr_data;
         if (start && !busy) begin
            case (req_mode)
               MODE_START: begin
                  placed_q   = req_placed_cost;
                  crossing_q = req_crossing_cost;
                  position_q = req_position;
                  suffix_q   = req_suffix_edges;
                  best_q     = req_best_so_far;
                  foreach (hist[i]) hist[i] = '0;
                  leaves_q = 1'b1;
               end
               MODE_BORDER: begin
                  if (hist[req_neighbor_count] != 8'hFF) hist[req_neighbor_count]++;
               end
               MODE_EDGE: begin
                  if (req_first_end_assigned) leaves_q = leaves_q && (req_second_end_degree == 1);
                  else if (req_second_end_assigned)
                     leaves_q = leaves_q && (req_first_end_degree == 1);
               end
               default: begin
                  expected_bounds.push_back(predict_bound());
               end
            endcase
         end
         if (rsp_valid) begin
            if (expected_bounds.size() == 0) begin
               report_mismatch("result with no finish request waiting", 0, 1);
            end else begin
               got = expected_bounds.pop_front();
               checked_count++;
               if (rsp_action !== got.action)
                  report_mismatch("action", got.action, rsp_action);
               if (rsp_upper_bound !== got.upper_bound)
                  report_mismatch("upper_bound", got.upper_bound, rsp_upper_bound);
            end
         end
      end
      pending_count = expected_bounds.size();
   end

endmodule

// File: dv/tb_max_arrangement_bound_decider.sv
`timescale 1ns / 1ps
// Testbench top for max_arrangement_bound_decider: drives directed and random
// search-step requests and register writes, and gives the verdict.
// Depends on mabd_pkg, the decider RTL and mabd_bound_checker.
module tb_max_arrangement_bound_decider;
   import mabd_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 280;

   typedef struct {
      mode_type    mode;
      logic [31:0] placed_cost;
      logic [31:0] crossing_cost;
      logic [7:0]  position;
      logic [7:0]  suffix_edges;
      logic [31:0] best_so_far;
      logic [7:0]  neighbor_count;
      logic        first_end_assigned;
      logic        second_end_assigned;
      logic [7:0]  first_end_degree;
      logic [7:0]  second_end_degree;
   } step_request_t;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_mode = '0;
   logic [31:0]       req_placed_cost = '0;
   logic [31:0]       req_crossing_cost = '0;
   logic [7:0]        req_position = '0;
   logic [7:0]        req_suffix_edges = '0;
   logic [31:0]       req_best_so_far = '0;
   logic [7:0]        req_neighbor_count = '0;
   logic              req_first_end_assigned = 1'b0;
   logic              req_second_end_assigned = 1'b0;
   logic [7:0]        req_first_end_degree = '0;
   logic [7:0]        req_second_end_degree = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_action;
   logic [31:0]       rsp_upper_bound;
   logic              csr_wr_en = 1'b0;
   logic [NODE_W-1:0] csr_wr_data = '0;

   int unsigned failures;
   int unsigned pending;
   int unsigned bounds_checked;
   int unsigned idle_cycles = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned mode_counts [4] = '{0, 0, 0, 0};
   int unsigned node_count_now = MAX_NODES;

   max_arrangement_bound_decider u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_mode                (req_mode),
      .req_placed_cost         (req_placed_cost),
      .req_crossing_cost       (req_crossing_cost),
      .req_position            (req_position),
      .req_suffix_edges        (req_suffix_edges),
      .req_best_so_far         (req_best_so_far),
      .req_neighbor_count      (req_neighbor_count),
      .req_first_end_assigned  (req_first_end_assigned),
      .req_second_end_assigned (req_second_end_assigned),
      .req_first_end_degree    (req_first_end_degree),
      .req_second_end_degree   (req_second_end_degree),
      .rsp_valid               (rsp_valid),
      .rsp_action              (rsp_action),
      .rsp_upper_bound         (rsp_upper_bound),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data)
   );

   mabd_bound_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_mode                (req_mode),
      .req_placed_cost         (req_placed_cost),
      .req_crossing_cost       (req_crossing_cost),
      .req_position            (req_position),
      .req_suffix_edges        (req_suffix_edges),
      .req_best_so_far         (req_best_so_far),
      .req_neighbor_count      (req_neighbor_count),
      .req_first_end_assigned  (req_first_end_assigned),
      .req_second_end_assigned (req_second_end_assigned),
      .req_first_end_degree    (req_first_end_degree),
      .req_second_end_degree   (req_second_end_degree),
      .rsp_valid               (rsp_valid),
      .rsp_action              (rsp_action),
      .rsp_upper_bound         (rsp_upper_bound),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .failures                (failures),
      .pending                 (pending),
      .bounds_checked          (bounds_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] no request or result accepted for %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic step_request_t blank_request(input mode_type mode);
      step_request_t r;
      r.mode                = mode;
      r.placed_cost         = $urandom;
      r.crossing_cost       = $urandom;
      r.position            = 8'($urandom);
      r.suffix_edges        = 8'($urandom);
      r.best_so_far         = $urandom;
      r.neighbor_count      = 8'($urandom);
      r.first_end_assigned  = 1'($urandom);
      r.second_end_assigned = 1'($urandom);
      r.first_end_degree    = 8'($urandom);
      r.second_end_degree   = 8'($urandom);
      return r;
   endfunction

   function automatic step_request_t start_request(input logic [31:0] placed,
         input logic [31:0] crossing, input logic [7:0] position,
         input logic [7:0] suffix_edges, input logic [31:0] best);
      step_request_t r;
      r = blank_request(MODE_START);
      r.placed_cost   = placed;
      r.crossing_cost = crossing;
      r.position      = position;
      r.suffix_edges  = suffix_edges;
      r.best_so_far   = best;
      return r;
   endfunction

   function automatic step_request_t border_request(input logic [7:0] neighbors);
      step_request_t r;
      r = blank_request(MODE_BORDER);
      r.neighbor_count = neighbors;
      return r;
   endfunction

   function automatic step_request_t edge_request(input logic first_assigned,
         input logic second_assigned, input logic [7:0] first_degree,
         input logic [7:0] second_degree);
      step_request_t r;
      r = blank_request(MODE_EDGE);
      r.first_end_assigned  = first_assigned;
      r.second_end_assigned = second_assigned;
      r.first_end_degree    = first_degree;
      r.second_end_degree   = second_degree;
      return r;
   endfunction

   function automatic logic [31:0] pick_cost();
      case ($urandom_range(3))
         0: return $urandom_range(1000);
         1: return 32'hFFFF_FFFF - $urandom_range(1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_degree();
      return ($urandom_range(9) < 7) ? 8'd1 : 8'($urandom_range(2, 255));
   endfunction

   // Entered and left at a falling edge; start stays high between back-to-back requests.
   task automatic send_request(input step_request_t r);
      int unsigned gap;
      gap = 0;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
         gap = ($urandom_range(9) == 0) ? $urandom_range(1, 280) : $urandom_range(1, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode                <= r.mode;
      req_placed_cost         <= r.placed_cost;
      req_crossing_cost       <= r.crossing_cost;
      req_position            <= r.position;
      req_suffix_edges        <= r.suffix_edges;
      req_best_so_far         <= r.best_so_far;
      req_neighbor_count      <= r.neighbor_count;
      req_first_end_assigned  <= r.first_end_assigned;
      req_second_end_assigned <= r.second_end_assigned;
      req_first_end_degree    <= r.first_end_degree;
      req_second_end_degree   <= r.second_end_degree;
      start                   <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      requests_sent++;
      mode_counts[r.mode]++;
   endtask

   // The sender holds off until every bound has come back and the block is idle.
   task automatic set_node_count(input int unsigned value);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= NODE_W'(value);
      @(negedge clock);
      csr_wr_en      <= 1'b0;
      node_count_now = value;
   endtask

   task automatic send_search_step();
      int unsigned borders;
      int unsigned edges;
      logic [7:0]  position;
      logic [7:0]  suffix_edges;
      logic [31:0] best;
      logic [7:0]  neighbors;
      position = $urandom_range(1) ? 8'($urandom_range(node_count_now - 1))
                                   : 8'($urandom_range(255));
      case ($urandom_range(3))
         0: suffix_edges = 8'd0;
         1: suffix_edges = 8'($urandom_range(1, 8));
         default: suffix_edges = 8'($urandom_range(255));
      endcase
      case ($urandom_range(3))
         0: best = $urandom_range(5000);
         1: best = 32'hFFFF_FFFF;
         default: best = $urandom;
      endcase
      send_request(start_request(pick_cost(), pick_cost(), position, suffix_edges, best));
      borders = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(12);
      edges   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4);
      while (borders + edges > 0) begin
         if (borders > 0 && (edges == 0 || $urandom_range(1))) begin
            case ($urandom_range(9))
               0: neighbors = 8'd0;
               1: neighbors = 8'd255;
               2, 3: neighbors = 8'($urandom_range(255));
               default: neighbors = 8'($urandom_range(1, 8));
            endcase
            send_request(border_request(neighbors));
            borders--;
         end else begin
            send_request(edge_request(1'($urandom), 1'($urandom), pick_degree(),
                                      pick_degree()));
            edges--;
         end
      end
      send_request(blank_request(MODE_FINISH));
      if ($urandom_range(4) == 0) send_request(blank_request(MODE_FINISH));
   endtask

   initial begin
      static int unsigned node_plan [PHASES] = '{256, 2, 256, 0, 3, 0, 255, 0};
      static int unsigned idle_plan [3] = '{0, 47, 24};
      int unsigned k;
      int          phase;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0)
            set_node_count(node_plan[phase] == 0 ? $urandom_range(4, 254) : node_plan[phase]);
         sender_idle_pct = idle_plan[phase % 3];
         if (phase == 0) begin
            send_request(start_request(0, 0, 0, 0, 0));
            send_request(blank_request(MODE_FINISH));
            send_request(start_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 255, 32'hFFFF_FFFF));
            send_request(border_request(255));
            send_request(border_request(255));
            send_request(border_request(0));
            send_request(border_request(1));
            send_request(edge_request(1'b1, 1'b0, 8'd7, 8'd1));
            send_request(edge_request(1'b1, 1'b1, 8'd5, 8'd5));
            send_request(blank_request(MODE_FINISH));
            send_request(blank_request(MODE_FINISH));
            send_request(start_request(10, 5, 250, 0, 1000));
            send_request(border_request(3));
            send_request(blank_request(MODE_FINISH));
            send_request(start_request(1, 2, 200, 0, 0));
            send_request(edge_request(1'b0, 1'b1, 8'd4, 8'd1));
            send_request(edge_request(1'b0, 1'b0, 8'd1, 8'd1));
            send_request(blank_request(MODE_FINISH));
            send_request(start_request(7, 9, 255, 255, 0));
            send_request(border_request(200));
            send_request(blank_request(MODE_FINISH));
            send_request(start_request(3, 4, 253, 1, 0));
            send_request(edge_request(1'b1, 1'b0, 8'd255, 8'd255));
            send_request(blank_request(MODE_FINISH));
         end
         if (phase == 2) begin
            // Enough repeats of one count to saturate its histogram entry.
            k = $urandom_range(1, 255);
            send_request(start_request(pick_cost(), pick_cost(), 0, 3, 0));
            repeat (260) send_request(border_request(8'(k)));
            send_request(border_request(8'(k - 1)));
            send_request(blank_request(MODE_FINISH));
         end
         while (requests_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            if ($urandom_range(7) == 0) send_request(blank_request(mode_type'($urandom_range(3))));
            else send_search_step();
         end
      end

      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d requests (%0d start, %0d border, %0d edge, %0d finish)",
               requests_sent, mode_counts[MODE_START], mode_counts[MODE_BORDER],
               mode_counts[MODE_EDGE], mode_counts[MODE_FINISH]);
      $display("%0d bounds compared over %0d node-count settings, %0d mismatches",
               bounds_checked, PHASES, failures);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/mabd_pkg.sv
rtl/core/max_arrangement_bound_decider.sv
dv/mabd_bound_checker.sv
dv/tb_max_arrangement_bound_decider.sv
